[design/ambd_pkg.sv]
`timescale 1ns / 1ps

package ambd_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W  = 1;
    localparam int         CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIVES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN  = 1'd1;

    // Memory geometry
    localparam int ROM_DEPTH  = 12288;
    localparam int ROM_AW     = 14;
    localparam int WORK_DEPTH = 2048;
    localparam int WORK_AW    = 11;
    localparam int CHAR_DEPTH = 1024;
    localparam int CHAR_AW    = 10;
    localparam int OBJ_DEPTH  = 256;
    localparam int OBJ_AW     = 8;

    localparam logic [15:0] ROM_LIMIT = 16'h3000;

    // Windows decoded on address bits 15..11
    localparam logic [4:0] WIN_WORK = 5'b10000;  // 8000-87FF
    localparam logic [4:0] WIN_CHAR = 5'b10101;  // A800-AFFF
    localparam logic [4:0] WIN_OBJ  = 5'b10110;  // B000-B7FF
    localparam logic [4:0] WIN_CTRL = 5'b10111;  // B800-BFFF
    localparam logic [1:0] WIN_PORT = 2'b11;     // C000-FFFF on bits 15..14

    // Control latch selects on address bits 4..2
    localparam logic [2:0] LATCH_NMI    = 3'd2;
    localparam logic [2:0] LATCH_FLIP_Y = 3'd3;
    localparam logic [2:0] LATCH_FLIP_X = 3'd4;

    // Parallel port selects on address bits 2..1
    localparam logic [1:0] PORT_IN0    = 2'd0;
    localparam logic [1:0] PORT_IN1    = 2'd1;
    localparam logic [1:0] PORT_IN2    = 2'd2;
    localparam logic [1:0] SND_COMMAND = 2'd0;
    localparam logic [1:0] SND_CONTROL = 2'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [6:0]  buttons;
    } t_item_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_enable;
        logic       flip_x;
        logic       flip_y;
        logic [7:0] sound_command;
        logic [7:0] sound_control_byte;
        logic       sound_irq_request;
    } t_result;

endpackage

[design/ambd_ram.sv]
`timescale 1ns / 1ps

module ambd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/arcade_main_bus_decoder_top.sv]
`timescale 1ns / 1ps

// Main CPU bus decoder: program ROM, work / character map / object RAM,
// control latches and two parallel ports.
//
// Use: drive i_item and raise start; the item is taken at a rising edge with
// start high and busy low. cmd selects bus read, bus write or ROM load.
// Exactly one result follows, on o_result with o_strobe high for a single
// cycle: the item passes through the stage 1 register and then the result
// register, which drives o_strobe. The receiver cannot stall: the result is
// gone after the strobe cycle.
// Throughput: one item per cycle while busy is low. The RAMs are read and
// written at the accepting edge; the registered read data is muxed into the
// result register at the next edge.
// Reset: synchronous, active low. It clears the latches and the switch
// registers, then the block holds busy high while a sweep zeroes the work,
// character map and object RAMs, one address per cycle.
// The program ROM keeps its contents; load it with ROM load items first.
// Switch registers are written through i_cfg_we / i_cfg_index / i_cfg_data at
// any time, also during the sweep.

module arcade_main_bus_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  ambd_pkg::t_item_in                   i_item,
    output logic                                 o_strobe,
    output ambd_pkg::t_result                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [ambd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ambd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Read source of an item in flight
    localparam logic [2:0] SRC_CONST = 3'd0;
    localparam logic [2:0] SRC_ROM   = 3'd1;
    localparam logic [2:0] SRC_WORK  = 3'd2;
    localparam logic [2:0] SRC_CHAR  = 3'd3;
    localparam logic [2:0] SRC_OBJ   = 3'd4;

    // ---------------------------------------------------------------- config
    logic [1:0] r_lives;
    logic [2:0] r_coin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lives <= '0;
            r_coin  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ambd_pkg::REG_LIVES: r_lives <= i_cfg_data[1:0];
                ambd_pkg::REG_COIN:  r_coin  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- clearing sweep
    logic                         r_clearing;
    logic [ambd_pkg::WORK_AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == {ambd_pkg::WORK_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign busy = r_clearing;

    // ------------------------------------------------------------- decode
    logic        w_accept;
    logic [15:0] w_addr;
    logic        w_is_read, w_is_write;
    logic        w_in_rom, w_in_work, w_in_char, w_in_obj, w_in_ctrl, w_in_port;

    assign w_accept   = start && !busy;
    assign w_addr     = i_item.address;
    assign w_is_read  = (i_item.cmd == ambd_pkg::CMD_READ);
    assign w_is_write = (i_item.cmd == ambd_pkg::CMD_WRITE);
    assign w_in_rom   = (w_addr < ambd_pkg::ROM_LIMIT);
    assign w_in_work  = (w_addr[15:11] == ambd_pkg::WIN_WORK);
    assign w_in_char  = (w_addr[15:11] == ambd_pkg::WIN_CHAR);
    assign w_in_obj   = (w_addr[15:11] == ambd_pkg::WIN_OBJ);
    assign w_in_ctrl  = (w_addr[15:11] == ambd_pkg::WIN_CTRL);
    assign w_in_port  = (w_addr[15:14] == ambd_pkg::WIN_PORT);

    // Input port value, active-low buttons merged with the switches
    logic [7:0] w_port_in;
    logic [7:0] w_port_rd;

    always_comb begin
        w_port_in = 8'hFF;
        case (w_addr[2:1])
            ambd_pkg::PORT_IN0: begin
                if (i_item.buttons[0]) w_port_in[4] = 1'b0;
                if (i_item.buttons[1]) w_port_in[5] = 1'b0;
                if (i_item.buttons[2]) w_port_in[7] = 1'b0;
            end
            ambd_pkg::PORT_IN1: begin
                w_port_in = {6'b111111, r_lives};
                if (i_item.buttons[4]) w_port_in[6] = 1'b0;
                if (i_item.buttons[3]) w_port_in[7] = 1'b0;
            end
            ambd_pkg::PORT_IN2: begin
                w_port_in = 8'hF1 | {4'b0000, r_coin, 1'b0};
                if (i_item.buttons[5]) w_port_in[4] = 1'b0;
                if (i_item.buttons[6]) w_port_in[6] = 1'b0;
            end
            default: w_port_in = 8'hFF;
        endcase
        w_port_rd = (w_addr[12] ? 8'h00 : 8'hFF) & (w_addr[13] ? w_port_in : 8'hFF);
    end

    // ----------------------------------------------------------- memories
    logic                         w_rom_we, w_work_we, w_char_we, w_obj_we;
    logic [ambd_pkg::WORK_AW-1:0] w_work_addr;
    logic [ambd_pkg::CHAR_AW-1:0] w_char_addr;
    logic [ambd_pkg::OBJ_AW-1:0]  w_obj_addr;
    logic [7:0]                   w_ram_wdata;
    logic [7:0]                   w_rom_rd, w_work_rd, w_char_rd, w_obj_rd;

    // The sweep owns the RAM ports while busy; no item is taken then
    assign w_rom_we    = w_accept && (i_item.cmd == ambd_pkg::CMD_LOAD) && w_in_rom;
    assign w_work_we   = r_clearing || (w_accept && w_is_write && w_in_work);
    assign w_char_we   = r_clearing || (w_accept && w_is_write && w_in_char);
    assign w_obj_we    = r_clearing || (w_accept && w_is_write && w_in_obj);
    assign w_work_addr = r_clearing ? r_clr_cnt : w_addr[ambd_pkg::WORK_AW-1:0];
    assign w_char_addr = r_clearing ? r_clr_cnt[ambd_pkg::CHAR_AW-1:0]
                                    : w_addr[ambd_pkg::CHAR_AW-1:0];
    assign w_obj_addr  = r_clearing ? r_clr_cnt[ambd_pkg::OBJ_AW-1:0]
                                    : w_addr[ambd_pkg::OBJ_AW-1:0];
    assign w_ram_wdata = r_clearing ? 8'h00 : i_item.write_data;

    ambd_ram #(.WIDTH(8), .DEPTH(ambd_pkg::ROM_DEPTH)) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_addr  (w_addr[ambd_pkg::ROM_AW-1:0]),
        .i_wdata (i_item.write_data),
        .o_rdata (w_rom_rd)
    );

    ambd_ram #(.WIDTH(8), .DEPTH(ambd_pkg::WORK_DEPTH)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_work_we),
        .i_addr  (w_work_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_work_rd)
    );

    ambd_ram #(.WIDTH(8), .DEPTH(ambd_pkg::CHAR_DEPTH)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_addr  (w_char_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_char_rd)
    );

    ambd_ram #(.WIDTH(8), .DEPTH(ambd_pkg::OBJ_DEPTH)) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (w_obj_we),
        .i_addr  (w_obj_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_obj_rd)
    );

    // ------------------------------------------------------------- latches
    logic       r_nmi, r_flip_x, r_flip_y;
    logic [7:0] r_snd_cmd, r_snd_ctrl;
    logic       n_nmi, n_flip_x, n_flip_y;
    logic [7:0] n_snd_cmd, n_snd_ctrl;
    logic       w_irq;

    always_comb begin
        n_nmi      = r_nmi;
        n_flip_x   = r_flip_x;
        n_flip_y   = r_flip_y;
        n_snd_cmd  = r_snd_cmd;
        n_snd_ctrl = r_snd_ctrl;
        w_irq      = 1'b0;
        if (w_accept && w_is_write && w_in_ctrl) begin
            case (w_addr[4:2])
                ambd_pkg::LATCH_NMI:    n_nmi    = i_item.write_data[0];
                ambd_pkg::LATCH_FLIP_Y: n_flip_y = i_item.write_data[0];
                ambd_pkg::LATCH_FLIP_X: n_flip_x = i_item.write_data[0];
                default: ;
            endcase
        end
        if (w_accept && w_is_write && w_in_port && w_addr[12]) begin
            case (w_addr[2:1])
                ambd_pkg::SND_COMMAND: n_snd_cmd = i_item.write_data;
                ambd_pkg::SND_CONTROL: begin
                    // request on a falling edge of control bit 3
                    w_irq      = r_snd_ctrl[3] && !i_item.write_data[3];
                    n_snd_ctrl = i_item.write_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nmi      <= 1'b0;
            r_flip_x   <= 1'b0;
            r_flip_y   <= 1'b0;
            r_snd_cmd  <= '0;
            r_snd_ctrl <= '0;
        end else begin
            r_nmi      <= n_nmi;
            r_flip_x   <= n_flip_x;
            r_flip_y   <= n_flip_y;
            r_snd_cmd  <= n_snd_cmd;
            r_snd_ctrl <= n_snd_ctrl;
        end
    end

    // --------------------------------------------- stage 1: RAM read in flight
    logic       r_s1_valid;
    logic [2:0] r_s1_src;
    logic [7:0] r_s1_const;
    logic       r_s1_irq;
    logic [2:0] n_s1_src;
    logic [7:0] n_s1_const;

    always_comb begin
        n_s1_src   = SRC_CONST;
        n_s1_const = 8'h00;
        if (w_is_read) begin
            n_s1_const = 8'hFF;
            if (w_in_rom) begin
                n_s1_src = SRC_ROM;
            end else if (w_in_work) begin
                n_s1_src = SRC_WORK;
            end else if (w_in_char) begin
                n_s1_src = SRC_CHAR;
            end else if (w_in_obj) begin
                n_s1_src = SRC_OBJ;
            end else if (w_in_port) begin
                n_s1_const = w_port_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_src   <= n_s1_src;
        r_s1_const <= n_s1_const;
        r_s1_irq   <= w_irq;
    end

    // --------------------------------------------------------- result stage
    logic       r_strobe;
    ambd_pkg::t_result r_result;
    logic [7:0] w_rd_mux;

    always_comb begin
        case (r_s1_src)
            SRC_ROM:  w_rd_mux = w_rom_rd;
            SRC_WORK: w_rd_mux = w_work_rd;
            SRC_CHAR: w_rd_mux = w_char_rd;
            SRC_OBJ:  w_rd_mux = w_obj_rd;
            default:  w_rd_mux = r_s1_const;
        endcase
    end

    // Latches read here already hold the values left by this item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s1_valid;
        end
        r_result.read_data          <= w_rd_mux;
        r_result.nmi_enable         <= r_nmi;
        r_result.flip_x             <= r_flip_x;
        r_result.flip_y             <= r_flip_y;
        r_result.sound_command      <= r_snd_cmd;
        r_result.sound_control_byte <= r_snd_ctrl;
        r_result.sound_irq_request  <= r_s1_irq;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---------------------------------------------------------- assertions
    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result strobe without an item two cycles earlier");

    a_irq_after_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.sound_irq_request) |-> !o_result.sound_control_byte[3])
        else $error("sound request with control bit 3 still set");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd != ambd_pkg::CMD_READ)
            |=> ##1 (o_strobe && o_result.read_data == 8'h00))
        else $error("non-read item returned nonzero data");

    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_cnt) == {ambd_pkg::WORK_AW{1'b1}})
        else $error("RAM clearing sweep ended early");

endmodule
